### hdl/mst_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mst_pkg
// Shared constants, opcodes and control types for the instruction step block.
// ----------------------------------------------------------------------------
package mst_pkg;

    localparam int MEM_BYTES = 16384;
    localparam int NUM_REGS = 32;
    localparam int REG_IDX_W = $clog2(NUM_REGS);
    localparam int WORD_W = 32;
    localparam int CFG_IDX_W = 1;

    localparam logic [WORD_W-1:0] CODE_START_RESET = 32'h0000_0000;
    localparam logic [WORD_W-1:0] DATA_BASE_RESET = 32'h0000_2000;

    localparam logic [5:0] FUNCT_ADD = 6'b100000;
    localparam logic [WORD_W-1:0] JUMP_REGION_MASK = 32'hF000_0000;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_CODE_START = 1'b0,
        CFG_DATA_BASE  = 1'b1
    } cfg_index_t;

    typedef enum logic [0:0] {
        FUNC_PRELOAD = 1'b0,
        FUNC_STEP    = 1'b1
    } func_t;

    typedef enum logic [5:0] {
        OP_RTYPE = 6'b000000,
        OP_BGE_A = 6'b000001,
        OP_JUMP  = 6'b000010,
        OP_BGE_B = 6'b000101,
        OP_ADDI  = 6'b001000,
        OP_LB    = 6'b100000,
        OP_LW    = 6'b100011,
        OP_SW    = 6'b101011,
        OP_LA    = 6'b101111
    } opcode_t;

    typedef enum logic [8:0] {
        ST_IDLE      = 9'b000000001,
        ST_FETCH     = 9'b000000010,
        ST_FETCH_END = 9'b000000100,
        ST_DECODE    = 9'b000001000,
        ST_EXEC      = 9'b000010000,
        ST_LOAD      = 9'b000100000,
        ST_LOAD_END  = 9'b001000000,
        ST_STORE     = 9'b010000000,
        ST_FINISH    = 9'b100000000
    } state_t;

    typedef struct packed {
        logic       load_item;
        logic       mem_rd;
        logic       rd_from_ea;
        logic       mem_wr;
        logic [1:0] byte_idx;
        logic       decode;
        logic       exec;
        logic       commit;
    } dp_cmd_t;

    typedef struct packed {
        logic stopped;
        logic word_zero;
        logic bad_op;
        logic is_lb;
        logic is_lw;
        logic is_sw;
    } dp_status_t;

endpackage
`default_nettype wire

### hdl/mst_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mst_ctrl
// Sequencer: walks preload store, or fetch, decode, execute, memory access and commit phases.
// ----------------------------------------------------------------------------
module mst_ctrl (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 s_valid,
    input  wire logic                 s_func,
    output logic                      s_ready,
    output logic                      m_valid,
    input  wire logic                 m_ready,
    output mst_pkg::dp_cmd_t          cmd,
    input  wire mst_pkg::dp_status_t  sts
);

    mst_pkg::state_t state_reg, state_next;
    logic [1:0]      cnt_reg, cnt_next;
    logic            m_valid_reg, m_valid_next;
    logic            out_free;

    assign s_ready  = (state_reg == mst_pkg::ST_IDLE);
    assign m_valid  = m_valid_reg;
    assign out_free = !m_valid_reg || m_ready;

    always_comb begin
        state_next   = state_reg;
        cnt_next     = cnt_reg;
        m_valid_next = m_valid_reg && !m_ready;
        cmd          = '0;
        cmd.byte_idx = cnt_reg;
        unique case (state_reg)
            mst_pkg::ST_IDLE: begin
                if (s_valid) begin
                    cmd.load_item = 1'b1;
                    cnt_next      = 2'd0;
                    if (s_func == mst_pkg::FUNC_PRELOAD) begin
                        state_next = mst_pkg::ST_STORE;
                    end else if (sts.stopped) begin
                        state_next = mst_pkg::ST_FINISH;
                    end else begin
                        state_next = mst_pkg::ST_FETCH;
                    end
                end
            end
            mst_pkg::ST_FETCH: begin
                cmd.mem_rd = 1'b1;
                cnt_next   = cnt_reg + 2'd1;
                if (cnt_reg == 2'd3) begin
                    state_next = mst_pkg::ST_FETCH_END;
                end
            end
            mst_pkg::ST_FETCH_END: begin
                state_next = mst_pkg::ST_DECODE;
            end
            mst_pkg::ST_DECODE: begin
                cmd.decode = 1'b1;
                if (sts.word_zero || sts.bad_op) begin
                    state_next = mst_pkg::ST_FINISH;
                end else begin
                    state_next = mst_pkg::ST_EXEC;
                end
            end
            mst_pkg::ST_EXEC: begin
                cmd.exec = 1'b1;
                cnt_next = 2'd0;
                if (sts.is_lb || sts.is_lw) begin
                    state_next = mst_pkg::ST_LOAD;
                end else if (sts.is_sw) begin
                    state_next = mst_pkg::ST_STORE;
                end else begin
                    state_next = mst_pkg::ST_FINISH;
                end
            end
            mst_pkg::ST_LOAD: begin
                cmd.mem_rd     = 1'b1;
                cmd.rd_from_ea = 1'b1;
                cnt_next       = cnt_reg + 2'd1;
                if (sts.is_lb || cnt_reg == 2'd3) begin
                    state_next = mst_pkg::ST_LOAD_END;
                end
            end
            mst_pkg::ST_LOAD_END: begin
                state_next = mst_pkg::ST_FINISH;
            end
            mst_pkg::ST_STORE: begin
                cmd.mem_wr = 1'b1;
                cnt_next   = cnt_reg + 2'd1;
                if (cnt_reg == 2'd3) begin
                    state_next = mst_pkg::ST_FINISH;
                end
            end
            mst_pkg::ST_FINISH: begin
                if (out_free) begin
                    cmd.commit   = 1'b1;
                    m_valid_next = 1'b1;
                    state_next   = mst_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = mst_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= mst_pkg::ST_IDLE;
            cnt_reg     <= 2'd0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            m_valid_reg <= m_valid_next;
        end
    end

endmodule
`default_nettype wire

### hdl/mst_datapath.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mst_datapath
// Program counter, register file, byte memory, execute logic and result item.
// ----------------------------------------------------------------------------
module mst_datapath #(
    parameter int MEM_BYTES = mst_pkg::MEM_BYTES,
    localparam int ADDR_W = $clog2(MEM_BYTES)
) (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           cfg_we,
    input  wire logic [mst_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [mst_pkg::WORD_W-1:0]     cfg_wdata,
    input  wire logic                           s_func,
    input  wire logic [ADDR_W-1:0]              s_addr,
    input  wire logic [mst_pkg::WORD_W-1:0]     s_data,
    input  wire mst_pkg::dp_cmd_t               cmd,
    output mst_pkg::dp_status_t                 sts,
    output logic [mst_pkg::WORD_W-1:0]          m_pc,
    output logic                                m_halted,
    output logic                                m_bad_opcode,
    output logic                                m_reg_write,
    output logic [mst_pkg::REG_IDX_W-1:0]       m_reg_index,
    output logic [mst_pkg::WORD_W-1:0]          m_reg_value,
    output logic                                m_mem_write,
    output logic [ADDR_W-1:0]                   m_mem_address,
    output logic [mst_pkg::WORD_W-1:0]          m_mem_value
);

    localparam int W = mst_pkg::WORD_W;
    localparam int RW = mst_pkg::REG_IDX_W;

    logic [7:0]     mem [MEM_BYTES];
    logic [W-1:0]   rf_mem [mst_pkg::NUM_REGS];
    logic [mst_pkg::NUM_REGS-1:0] rf_valid_reg;

    logic           func_reg;
    logic [ADDR_W-1:0] item_addr_reg;
    logic [W-1:0]   item_data_reg;
    logic [W-1:0]   pc_reg;
    logic           stopped_reg;
    logic [W-1:0]   data_base_reg;
    logic           cap_reg;
    logic           cap_instr_reg;
    logic [7:0]     rdata_reg;
    logic [W-1:0]   instr_reg;
    logic [W-1:0]   load_reg;
    logic [W-1:0]   rs_val_reg;
    logic [W-1:0]   rt_val_reg;
    logic [W-1:0]   pc4_reg;
    logic [W-1:0]   br_reg;
    logic [W-1:0]   ea_reg;
    logic [W-1:0]   alu_reg;
    logic [W-1:0]   next_pc_reg;

    logic [5:0]     op;
    logic [RW-1:0]  rs_idx;
    logic [RW-1:0]  rt_idx;
    logic [RW-1:0]  rd_idx;
    logic [W-1:0]   imm_sext;
    logic           known_op;
    logic [ADDR_W-1:0] mem_base;
    logic [ADDR_W-1:0] mem_addr;
    logic [W-1:0]   st_word;
    logic [7:0]     st_byte;
    logic           bge_ge;
    logic [W-1:0]   exec_next_pc;
    logic [W-1:0]   exec_alu;

    logic           step_run;
    logic           run_instr;
    logic           res_halted;
    logic           res_bad;
    logic           res_rw;
    logic [RW-1:0]  res_ri;
    logic [W-1:0]   res_rv;
    logic           res_mw;
    logic [ADDR_W-1:0] res_ma;
    logic [W-1:0]   res_mv;

    assign op       = instr_reg[31:26];
    assign rs_idx   = instr_reg[25:21];
    assign rt_idx   = instr_reg[20:16];
    assign rd_idx   = instr_reg[15:11];
    assign imm_sext = {{16{instr_reg[15]}}, instr_reg[15:0]};

    always_comb begin
        known_op   = 1'b1;
        sts.is_lb  = 1'b0;
        sts.is_lw  = 1'b0;
        sts.is_sw  = 1'b0;
        unique case (op)
            mst_pkg::OP_RTYPE, mst_pkg::OP_BGE_A, mst_pkg::OP_JUMP, mst_pkg::OP_BGE_B,
            mst_pkg::OP_ADDI, mst_pkg::OP_LA: begin
                known_op = 1'b1;
            end
            mst_pkg::OP_LB: sts.is_lb = 1'b1;
            mst_pkg::OP_LW: sts.is_lw = 1'b1;
            mst_pkg::OP_SW: sts.is_sw = 1'b1;
            default: known_op = 1'b0;
        endcase
        sts.stopped   = stopped_reg;
        sts.word_zero = (instr_reg == '0);
        sts.bad_op    = !known_op;
    end

    // memory address and store data
    assign mem_base = cmd.mem_wr ? ((func_reg == mst_pkg::FUNC_PRELOAD) ? item_addr_reg
                                                                          : ea_reg[ADDR_W-1:0])
                                 : (cmd.rd_from_ea ? ea_reg[ADDR_W-1:0] : pc_reg[ADDR_W-1:0]);
    assign mem_addr = mem_base + ADDR_W'(cmd.byte_idx);
    assign st_word  = (func_reg == mst_pkg::FUNC_PRELOAD) ? item_data_reg : rt_val_reg;

    always_comb begin
        unique case (cmd.byte_idx)
            2'd0: st_byte = st_word[31:24];
            2'd1: st_byte = st_word[23:16];
            2'd2: st_byte = st_word[15:8];
            2'd3: st_byte = st_word[7:0];
            default: st_byte = st_word[7:0];
        endcase
    end

    always_ff @(posedge aclk) begin
        if (cmd.mem_wr) begin
            mem[mem_addr] <= st_byte;
        end
        if (cmd.mem_rd) begin
            rdata_reg <= mem[mem_addr];
        end
    end

    // execute
    always_comb begin
        bge_ge = ($signed(rs_val_reg) >= $signed(rt_val_reg));
        unique case (op)
            mst_pkg::OP_BGE_A, mst_pkg::OP_BGE_B: exec_next_pc = bge_ge ? br_reg : pc4_reg;
            mst_pkg::OP_JUMP: exec_next_pc = ((pc4_reg & mst_pkg::JUMP_REGION_MASK)
                                             | {4'b0000, instr_reg[25:0], 2'b00}) - 32'd4;
            default: exec_next_pc = pc4_reg;
        endcase
        unique case (op)
            mst_pkg::OP_RTYPE: exec_alu = rs_val_reg + rt_val_reg;
            mst_pkg::OP_LA:    exec_alu = {16'h0000, instr_reg[15:0]} + data_base_reg;
            default:           exec_alu = rs_val_reg + imm_sext;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_item) begin
            func_reg      <= s_func;
            item_addr_reg <= s_addr;
            item_data_reg <= s_data;
        end
        if (cap_reg) begin
            if (cap_instr_reg) begin
                instr_reg <= {instr_reg[23:0], rdata_reg};
            end else begin
                load_reg <= {load_reg[23:0], rdata_reg};
            end
        end
        if (cmd.decode) begin
            rs_val_reg <= rf_valid_reg[rs_idx] ? rf_mem[rs_idx] : '0;
            rt_val_reg <= rf_valid_reg[rt_idx] ? rf_mem[rt_idx] : '0;
            pc4_reg    <= pc_reg + 32'd4;
            br_reg     <= pc_reg + {imm_sext[29:0], 2'b00};
        end
        if (cmd.exec) begin
            ea_reg      <= rs_val_reg + imm_sext;
            alu_reg     <= exec_alu;
            next_pc_reg <= exec_next_pc;
        end
        if (cmd.commit && res_rw) begin
            rf_mem[res_ri] <= res_rv;
        end
        if (cmd.commit) begin
            m_pc          <= pc_reg;
            m_halted      <= res_halted;
            m_bad_opcode  <= res_bad;
            m_reg_write   <= res_rw;
            m_reg_index   <= res_ri;
            m_reg_value   <= res_rv;
            m_mem_write   <= res_mw;
            m_mem_address <= res_ma;
            m_mem_value   <= res_mv;
        end
    end

    // result of the item
    always_comb begin
        step_run   = (func_reg == mst_pkg::FUNC_STEP) && !stopped_reg;
        run_instr  = step_run && !sts.word_zero;
        res_halted = stopped_reg || (step_run && sts.word_zero);
        res_bad    = run_instr && sts.bad_op;
        res_rw     = 1'b0;
        res_ri     = rt_idx;
        unique case (op)
            mst_pkg::OP_RTYPE: begin
                res_rw = (instr_reg[5:0] == mst_pkg::FUNCT_ADD);
                res_ri = rd_idx;
            end
            mst_pkg::OP_LA, mst_pkg::OP_LB, mst_pkg::OP_LW, mst_pkg::OP_ADDI: begin
                res_rw = 1'b1;
            end
            default: res_rw = 1'b0;
        endcase
        res_rw = res_rw && run_instr;
        unique case (op)
            mst_pkg::OP_LB: res_rv = {{24{load_reg[7]}}, load_reg[7:0]};
            mst_pkg::OP_LW: res_rv = load_reg;
            default:        res_rv = alu_reg;
        endcase
        if (!res_rw) begin
            res_ri = '0;
            res_rv = '0;
        end
        res_mw = run_instr && sts.is_sw;
        res_ma = res_mw ? ea_reg[ADDR_W-1:0] : '0;
        res_mv = res_mw ? rt_val_reg : '0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pc_reg        <= mst_pkg::CODE_START_RESET;
            stopped_reg   <= 1'b0;
            data_base_reg <= mst_pkg::DATA_BASE_RESET;
            rf_valid_reg  <= '0;
            cap_reg       <= 1'b0;
            cap_instr_reg <= 1'b0;
        end else begin
            cap_reg       <= cmd.mem_rd;
            cap_instr_reg <= !cmd.rd_from_ea;
            if (cfg_we) begin
                unique case (mst_pkg::cfg_index_t'(cfg_index))
                    mst_pkg::CFG_CODE_START: ;
                    mst_pkg::CFG_DATA_BASE:  data_base_reg <= cfg_wdata;
                    default: ;
                endcase
            end
            if (cmd.commit) begin
                if (res_rw) begin
                    rf_valid_reg[res_ri] <= 1'b1;
                end
                if (run_instr) begin
                    pc_reg <= sts.bad_op ? pc4_reg : next_pc_reg;
                end
                if (step_run && (sts.word_zero || sts.bad_op)) begin
                    stopped_reg <= 1'b1;
                end
            end
        end
    end

endmodule
`default_nettype wire

### hdl/mips_subset_instruction_step.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mips_subset_instruction_step
// Byte-memory MIPS subset interpreter: preload words or step one instruction.
// Preload writes one word; a step fetches a word, then lb, lw and sw add a memory access.
// A zero word or unknown opcode ends after decode; a step while stopped skips to the result.
// The single byte-wide memory port moves one byte per cycle for fetch, load and store.
// The result is held in an output register; its handoff overlaps the next item.
// Reset (aresetn low, synchronous) clears pc, registers and stop flag and sets config to its reset value.
// ----------------------------------------------------------------------------
module mips_subset_instruction_step #(
    parameter int MEM_BYTES = mst_pkg::MEM_BYTES,
    localparam int ADDR_W = $clog2(MEM_BYTES)
) (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           cfg_valid,
    output logic                                cfg_ready,
    input  wire logic [mst_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [mst_pkg::WORD_W-1:0]     cfg_wdata,
    input  wire logic                           s_valid,
    output logic                                s_ready,
    input  wire logic                           s_func,
    input  wire logic [ADDR_W-1:0]              s_addr,
    input  wire logic [mst_pkg::WORD_W-1:0]     s_data,
    output logic                                m_valid,
    input  wire logic                           m_ready,
    output logic [mst_pkg::WORD_W-1:0]          m_pc,
    output logic                                m_halted,
    output logic                                m_bad_opcode,
    output logic                                m_reg_write,
    output logic [mst_pkg::REG_IDX_W-1:0]       m_reg_index,
    output logic [mst_pkg::WORD_W-1:0]          m_reg_value,
    output logic                                m_mem_write,
    output logic [ADDR_W-1:0]                   m_mem_address,
    output logic [mst_pkg::WORD_W-1:0]          m_mem_value
);

    mst_pkg::dp_cmd_t    cmd;
    mst_pkg::dp_status_t sts;
    logic                cfg_we;

    assign cfg_ready = 1'b1;
    assign cfg_we    = cfg_valid && cfg_ready;

    mst_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_func  (s_func),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .cmd     (cmd),
        .sts     (sts)
    );

    mst_datapath #(
        .MEM_BYTES (MEM_BYTES)
    ) u_datapath (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata),
        .s_func        (s_func),
        .s_addr        (s_addr),
        .s_data        (s_data),
        .cmd           (cmd),
        .sts           (sts),
        .m_pc          (m_pc),
        .m_halted      (m_halted),
        .m_bad_opcode  (m_bad_opcode),
        .m_reg_write   (m_reg_write),
        .m_reg_index   (m_reg_index),
        .m_reg_value   (m_reg_value),
        .m_mem_write   (m_mem_write),
        .m_mem_address (m_mem_address),
        .m_mem_value   (m_mem_value)
    );

endmodule
`default_nettype wire
